// File: rtl/sfps_pkg.sv
package sfps_pkg;

  localparam logic [7:0] SYNC_S = 8'h73;
  localparam logic [7:0] SYNC_N = 8'h6E;
  localparam logic [7:0] SYNC_P = 8'h70;

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_WANT_N  = 4'd1;
  localparam logic [3:0] PH_WANT_P  = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_LEN     = 4'd4;
  localparam logic [3:0] PH_PAYLOAD = 4'd5;
  localparam logic [3:0] PH_CK_HI   = 4'd6;
  localparam logic [3:0] PH_CK_LO   = 4'd7;
  localparam logic [3:0] PH_SKIP    = 4'd8;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_CK_ERR  = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] running_sum;
    logic [7:0]  held_type;
    logic [7:0]  held_length;
    logic [7:0]  payload_count;
    logic [7:0]  checksum_high;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_type;
    logic [7:0]  payload_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
  } parse_result_t;

endpackage

// File: rtl/sync_frame_parser_sum16.sv
// Latency: a result item is presented from the result register after its input
// item has passed through the input register; some items yield none.
// Throughput: one item per cycle; the stages stall only on out_ready_i.
// Reset: rst_ni is asynchronous and active low; it empties both stages and
// puts the parser back to hunting for the start byte with a zero sum.
module sync_frame_parser_sum16 import sfps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        last_in_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  frame_type_o,
  output logic [7:0]  payload_length_o,
  output logic [15:0] received_checksum_o,
  output logic [15:0] computed_checksum_o
);

  // Input register: holds one received byte and its end-of-buffer mark.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Parser state and the registered result item.
  parse_state_t  state_q, state_d;
  parse_result_t step_res;
  parse_result_t res_q;

  logic advance;

  // Advance the held item whenever the result slot is free or is being taken.
  assign advance    = in_valid_q && (!res_q.valid || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  sfps_step u_step (
    .state_i  (state_q),
    .rx_byte_i(in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Capture a new item whenever the input register frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= last_in_buffer_i;
    end
  end

  // Commit the parser state once per item that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on advance (possibly with no result), drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (advance) begin
      res_q <= step_res;
    end else if (out_ready_i) begin
      res_q.valid <= 1'b0;
    end
  end

  assign out_valid_o         = res_q.valid;
  assign kind_o              = res_q.kind;
  assign payload_byte_o      = res_q.payload_byte;
  assign payload_index_o     = res_q.payload_index;
  assign frame_type_o        = res_q.frame_type;
  assign payload_length_o    = res_q.payload_length;
  assign received_checksum_o = res_q.received_checksum;
  assign computed_checksum_o = res_q.computed_checksum;

endmodule

// File: rtl/sfps_step.sv
module sfps_step import sfps_pkg::*; (
  input  parse_state_t  state_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          last_i,
  output parse_state_t  state_o,
  output parse_result_t result_o
);

  logic        end_check;
  logic [3:0]  after_report;
  logic [15:0] sum_plus;
  logic [15:0] rx_check;
  logic [7:0]  count_plus;

  assign after_report = last_i ? PH_HUNT : PH_SKIP;
  assign sum_plus     = state_i.running_sum + {8'd0, rx_byte_i};
  assign rx_check     = {state_i.checksum_high, rx_byte_i};
  assign count_plus   = state_i.payload_count + 8'd1;

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    end_check = 1'b0;
    case (state_i.phase)
      PH_HUNT: begin
        end_check = 1'b1;
        if (rx_byte_i == SYNC_S) begin
          state_o.running_sum = {8'd0, SYNC_S};
          state_o.phase       = PH_WANT_N;
        end
      end
      PH_WANT_N: begin
        if (rx_byte_i != SYNC_N) begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_NONE;
          state_o.phase  = after_report;
        end else begin
          end_check           = 1'b1;
          state_o.running_sum = sum_plus;
          state_o.phase       = PH_WANT_P;
        end
      end
      PH_WANT_P: begin
        if (rx_byte_i != SYNC_P) begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_NONE;
          state_o.phase  = after_report;
        end else begin
          end_check           = 1'b1;
          state_o.running_sum = sum_plus;
          state_o.phase       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        end_check           = 1'b1;
        state_o.held_type   = rx_byte_i;
        state_o.running_sum = sum_plus;
        state_o.phase       = PH_LEN;
      end
      PH_LEN: begin
        end_check             = 1'b1;
        state_o.held_length   = rx_byte_i;
        state_o.running_sum   = sum_plus;
        state_o.payload_count = 8'd0;
        state_o.phase         = (rx_byte_i == 8'd0) ? PH_CK_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result_o.valid = 1'b1;
        if (last_i) begin
          result_o.kind = KIND_NONE;
          state_o.phase = PH_HUNT;
        end else begin
          result_o.kind           = KIND_PAYLOAD;
          result_o.payload_byte   = rx_byte_i;
          result_o.payload_index  = state_i.payload_count;
          result_o.frame_type     = state_i.held_type;
          result_o.payload_length = state_i.held_length;
          state_o.running_sum     = sum_plus;
          state_o.payload_count   = count_plus;
          if (count_plus == state_i.held_length) begin
            state_o.phase = PH_CK_HI;
          end
        end
      end
      PH_CK_HI: begin
        end_check             = 1'b1;
        state_o.checksum_high = rx_byte_i;
        state_o.phase         = PH_CK_LO;
      end
      PH_CK_LO: begin
        result_o.valid             = 1'b1;
        result_o.kind              = (rx_check == state_i.running_sum) ? KIND_OK
                                                                       : KIND_CK_ERR;
        result_o.frame_type        = state_i.held_type;
        result_o.payload_length    = state_i.held_length;
        result_o.received_checksum = rx_check;
        result_o.computed_checksum = state_i.running_sum;
        state_o.phase              = after_report;
      end
      default: begin
        state_o.phase = last_i ? PH_HUNT : PH_SKIP;
      end
    endcase

    // buffer ran out while hunting or before the frame finished
    if (end_check && last_i) begin
      result_o       = '0;
      result_o.valid = 1'b1;
      result_o.kind  = KIND_NONE;
      state_o.phase  = PH_HUNT;
    end
  end

endmodule
